// ===== hw/rtl/msfc_pkg.sv =====
package msfc_pkg;

  // crc-24 generator, remainder kept to 24 bits
  localparam logic [23:0] CRC_GEN     = 24'hFFF409;
  localparam logic [3:0]  SHORT_BYTES = 4'd7;
  localparam logic [3:0]  LONG_BYTES  = 4'd14;
  localparam logic [3:0]  COUNT_MAX   = 4'd15;

  // status codes, in priority order
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd1;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ST_BAD_PARITY = 2'd3;

  // message classes
  localparam logic [2:0] CLS_IDENT    = 3'd0;
  localparam logic [2:0] CLS_SURFACE  = 3'd1;
  localparam logic [2:0] CLS_AIRBORNE = 3'd2;
  localparam logic [2:0] CLS_VELOCITY = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN  = 3'd4;

  typedef struct packed {
    logic [1:0]  status;
    logic        long_frame;
    logic [4:0]  downlink_format;
    logic [2:0]  capability;
    logic [23:0] aircraft_address;
    logic [55:0] message_body;
    logic [4:0]  type_code;
    logic [2:0]  message_class;
  } msfc_result_t;

  // fold one byte into the remainder, msb first
  function automatic logic [23:0] crc_fold(input logic [23:0] rem, input logic [7:0] data);
    logic [23:0] r;
    r = rem ^ {data, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      if (r[23]) begin
        r = {r[22:0], 1'b0} ^ CRC_GEN;
      end else begin
        r = {r[22:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] class_of(input logic [4:0] tc);
    logic [2:0] cls;
    unique case (tc) inside
      [5'd1:5'd4]:                cls = CLS_IDENT;
      [5'd5:5'd8]:                cls = CLS_SURFACE;
      [5'd9:5'd18], [5'd20:5'd22]: cls = CLS_AIRBORNE;
      5'd19:                      cls = CLS_VELOCITY;
      default:                    cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

// ===== hw/rtl/msfc_if.sv =====
// byte stream into the checker
interface msfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// one report per frame
interface msfc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        long_frame;
  logic [4:0]  downlink_format;
  logic [2:0]  capability;
  logic [23:0] aircraft_address;
  logic [55:0] message_body;
  logic [4:0]  type_code;
  logic [2:0]  message_class;

  modport source (output valid, output status, output long_frame, output downlink_format,
                  output capability, output aircraft_address, output message_body,
                  output type_code, output message_class, input ready);
  modport sink (input valid, input status, input long_frame, input downlink_format,
                input capability, input aircraft_address, input message_body,
                input type_code, input message_class, output ready);
endinterface

// ===== hw/rtl/msfc_frame_acc.sv =====
module msfc_frame_acc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            frame_byte,
  input  logic                  last_byte,
  output logic                  res_valid,
  output msfc_pkg::msfc_result_t res
);
  import msfc_pkg::*;

  logic [23:0] crc;
  logic [23:0] crc_next;
  logic [3:0]  byte_count;
  logic [3:0]  count_next;
  logic [7:0]  header_byte;
  logic [7:0]  header_next;
  logic [23:0] address_shift;
  logic [23:0] address_next;
  logic [55:0] body_shift;
  logic [55:0] body_next;
  logic [4:0]  tc;
  logic [2:0]  cls;
  logic        is_long;

  // byte-wide crc update and position count
  assign crc_next   = crc_fold(crc, frame_byte);
  assign count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 4'd1;

  // latch header, address and body bytes by position
  always_comb begin
    header_next  = header_byte;
    address_next = address_shift;
    body_next    = body_shift;
    case (byte_count)
      4'd0: begin
        header_next  = frame_byte;
        address_next = '0;
        body_next    = '0;
      end
      4'd1:  address_next[23:16] = frame_byte;
      4'd2:  address_next[15:8]  = frame_byte;
      4'd3:  address_next[7:0]   = frame_byte;
      4'd4:  body_next[55:48]    = frame_byte;
      4'd5:  body_next[47:40]    = frame_byte;
      4'd6:  body_next[39:32]    = frame_byte;
      4'd7:  body_next[31:24]    = frame_byte;
      4'd8:  body_next[23:16]    = frame_byte;
      4'd9:  body_next[15:8]     = frame_byte;
      4'd10: body_next[7:0]      = frame_byte;
      default: begin
      end
    endcase
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= '0;
      byte_count    <= '0;
      header_byte   <= '0;
      address_shift <= '0;
      body_shift    <= '0;
    end else if (accept) begin
      header_byte   <= header_next;
      address_shift <= address_next;
      body_shift    <= body_next;
      if (last_byte) begin
        crc        <= '0;
        byte_count <= '0;
      end else begin
        crc        <= crc_next;
        byte_count <= count_next;
      end
    end
  end

  // report formed from the state as it stands after this byte
  assign tc      = body_next[55:51];
  assign cls     = class_of(tc);
  assign is_long = (count_next == LONG_BYTES);

  always_comb begin
    if (cls == CLS_UNKNOWN) begin
      res.status = ST_BAD_TYPE;
    end else if (count_next != SHORT_BYTES && count_next != LONG_BYTES) begin
      res.status = ST_BAD_LENGTH;
    end else if (crc_next != 24'd0) begin
      res.status = ST_BAD_PARITY;
    end else begin
      res.status = ST_OK;
    end
    res.long_frame       = is_long;
    res.downlink_format  = header_next[7:3];
    res.capability       = header_next[2:0];
    res.aircraft_address = address_next;
    res.message_body     = is_long ? body_next : 56'd0;
    res.type_code        = tc;
    res.message_class    = cls;
  end

  assign res_valid = accept && last_byte;

  // frame state restarts after every last byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> byte_count == 4'd0 && crc == 24'd0)
    else $error("frame state not cleared after last byte");

  // count advances by one per middle byte until saturation
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte && byte_count != COUNT_MAX |=> byte_count == $past(byte_count) + 4'd1)
    else $error("byte count did not advance");

  // a clean report has a known class and a legal length
  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_OK |->
      res.message_class != CLS_UNKNOWN &&
      (count_next == SHORT_BYTES || count_next == LONG_BYTES))
    else $error("ok status on a malformed frame");

endmodule

// ===== hw/rtl/mode_s_frame_checker_top.sv =====
// channel | role  | payload
// frame   | sink  | frame_byte[7:0], last_byte
// report  | source| status, long_frame, downlink_format, capability,
//         |       | aircraft_address, message_body, type_code, message_class
//
// one byte taken per cycle while frame.ready is high; crc fold, field latch and checks finish in that cycle
// the report is registered in the buffer and, with the buffer empty, shows the cycle after the last byte is taken
// a two-entry report buffer keeps bytes flowing while a report waits
// frame.ready drops only while both report entries are held
// rst is synchronous and clears frame state and the report buffer
module mode_s_frame_checker_top (
  input logic          clk,
  input logic          rst,
  msfc_byte_if.sink    frame,
  msfc_result_if.source report
);
  import msfc_pkg::*;

  logic         byte_accept;
  logic         res_valid;
  msfc_result_t res;
  msfc_result_t entry0;
  msfc_result_t entry1;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign frame.ready = (fill != 2'd2);
  assign byte_accept = frame.valid && frame.ready;

  // frame accumulation and checks
  msfc_frame_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .accept     (byte_accept),
    .frame_byte (frame.frame_byte),
    .last_byte  (frame.last_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign push = res_valid;
  assign pop  = report.valid && report.ready;

  // report buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // report buffer entries, entry0 is the head
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) begin
        entry0 <= res;
      end else begin
        entry0 <= entry1;
        entry1 <= res;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        entry0 <= res;
      end else begin
        entry1 <= res;
      end
    end else if (pop) begin
      entry0 <= entry1;
    end
  end

  // report outputs
  assign report.valid            = (fill != 2'd0);
  assign report.status           = entry0.status;
  assign report.long_frame       = entry0.long_frame;
  assign report.downlink_format  = entry0.downlink_format;
  assign report.capability       = entry0.capability;
  assign report.aircraft_address = entry0.aircraft_address;
  assign report.message_body     = entry0.message_body;
  assign report.type_code        = entry0.type_code;
  assign report.message_class    = entry0.message_class;

  // buffer never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("report buffer overflow");

  // a report is never pushed into a full buffer
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !push)
    else $error("report pushed while buffer full");

  // a last byte with no pending report shows up next cycle
  a_report_latency: assert property (@(posedge clk) disable iff (rst)
    push && fill == 2'd0 |=> report.valid && report.status == $past(res.status))
    else $error("report not presented after last byte");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import msfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 250;

  logic clk;
  logic rst;

  msfc_byte_if   frame_ch ();
  msfc_result_if report_ch ();

  mode_s_frame_checker_top dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .report (report_ch)
  );

  // frame tracking state of the predictor
  logic [23:0] pred_crc  = '0;
  logic [3:0]  pred_pos  = '0;
  logic [7:0]  pred_hdr  = '0;
  logic [23:0] pred_addr = '0;
  logic [55:0] pred_body = '0;

  msfc_result_t expected_reports[$];
  logic [7:0]   frame_octets[$];

  int src_gap_max       = 0;
  int sink_gap_max      = 0;
  int sink_hold_cycles  = 0;
  int mismatch_count    = 0;
  int octets_sent       = 0;
  int frames_sent       = 0;
  int reports_checked   = 0;
  int status_tally[4]   = '{0, 0, 0, 0};
  int cycle_count       = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // bit-serial crc-24, msb first
  function automatic logic [23:0] crc_after_octet(input logic [23:0] rem,
                                                  input logic [7:0] octet);
    logic [23:0] r;
    logic        fb;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      fb = r[23] ^ octet[i];
      r  = {r[22:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_GEN;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] class_for_type(input logic [4:0] tc);
    if (tc == 5'd0 || tc >= 5'd23) begin
      return CLS_UNKNOWN;
    end else if (tc <= 5'd4) begin
      return CLS_IDENT;
    end else if (tc <= 5'd8) begin
      return CLS_SURFACE;
    end else if (tc == 5'd19) begin
      return CLS_VELOCITY;
    end
    return CLS_AIRBORNE;
  endfunction

  // fold one accepted byte into the frame state, queue a report on the last byte
  task automatic predict_frame_report(input logic [7:0] octet, input logic is_last);
    msfc_result_t rpt;
    int           pos;
    logic [4:0]   tc;
    logic [2:0]   cls;
    logic         is_long;
    pos = int'(pred_pos);
    if (pos == 0) begin
      pred_hdr  = octet;
      pred_addr = '0;
      pred_body = '0;
    end else if (pos <= 3) begin
      pred_addr[8 * (3 - pos) +: 8] = octet;
    end else if (pos <= 10) begin
      pred_body[8 * (10 - pos) +: 8] = octet;
    end
    pred_crc = crc_after_octet(pred_crc, octet);
    if (pred_pos != COUNT_MAX) begin
      pred_pos = pred_pos + 4'd1;
    end
    if (is_last) begin
      tc      = pred_body[55:51];
      cls     = class_for_type(tc);
      is_long = (pred_pos == LONG_BYTES);
      if (cls == CLS_UNKNOWN) begin
        rpt.status = ST_BAD_TYPE;
      end else if (pred_pos != SHORT_BYTES && pred_pos != LONG_BYTES) begin
        rpt.status = ST_BAD_LENGTH;
      end else if (pred_crc != 24'd0) begin
        rpt.status = ST_BAD_PARITY;
      end else begin
        rpt.status = ST_OK;
      end
      rpt.long_frame       = is_long;
      rpt.downlink_format  = pred_hdr[7:3];
      rpt.capability       = pred_hdr[2:0];
      rpt.aircraft_address = pred_addr;
      rpt.message_body     = is_long ? pred_body : 56'd0;
      rpt.type_code        = tc;
      rpt.message_class    = cls;
      expected_reports.push_back(rpt);
      pred_crc = '0;
      pred_pos = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("report %0d: %s expected %0h got %0h", reports_checked, name, want, got);
      end
    end
  endtask

  // compare one report transaction with the oldest expectation
  task automatic check_report(input msfc_result_t got);
    msfc_result_t want;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected report: status %0d address %0h", got.status,
                 got.aircraft_address);
      end
      return;
    end
    want = expected_reports.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("long_frame", 64'(want.long_frame), 64'(got.long_frame));
    compare_field("downlink_format", 64'(want.downlink_format),
                  64'(got.downlink_format));
    compare_field("capability", 64'(want.capability), 64'(got.capability));
    compare_field("aircraft_address", 64'(want.aircraft_address),
                  64'(got.aircraft_address));
    compare_field("message_body", 64'(want.message_body), 64'(got.message_body));
    compare_field("type_code", 64'(want.type_code), 64'(got.type_code));
    compare_field("message_class", 64'(want.message_class), 64'(got.message_class));
    status_tally[want.status]++;
    reports_checked++;
  endtask

  // report receiver with random stalls and an optional long hold-off
  initial begin : report_sink
    int           stall_left;
    msfc_result_t got;
    stall_left = 0;
    report_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (report_ch.valid && report_ch.ready) begin
        got = '{status: report_ch.status, long_frame: report_ch.long_frame,
                downlink_format: report_ch.downlink_format,
                capability: report_ch.capability,
                aircraft_address: report_ch.aircraft_address,
                message_body: report_ch.message_body,
                type_code: report_ch.type_code,
                message_class: report_ch.message_class};
        check_report(got);
        stall_left = $urandom_range(0, sink_gap_max);
      end
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        report_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // one byte transaction, called at a rising edge
  task automatic send_octet(input logic [7:0] octet, input logic is_last);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.frame_byte <= octet;
    frame_ch.last_byte  <= is_last;
    do @(posedge clk); while (!frame_ch.ready);
    predict_frame_report(octet, is_last);
    octets_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_octets[i]) begin
      send_octet(frame_octets[i], i == frame_octets.size() - 1);
    end
    frames_sent++;
  endtask

  // random frame content with the type code placed where a long frame carries it
  task automatic build_frame(input int nbytes, input logic [4:0] tc);
    frame_octets.delete();
    for (int i = 0; i < nbytes; i++) begin
      frame_octets.push_back(8'($urandom_range(0, 255)));
    end
    if (nbytes >= 5) begin
      frame_octets[4][7:3] = tc;
    end
  endtask

  // overwrite the last three bytes with the parity of the rest
  task automatic seal_frame();
    logic [23:0] rem;
    int          n;
    n   = frame_octets.size();
    rem = '0;
    if (n < 4) begin
      return;
    end
    for (int i = 0; i < n - 3; i++) begin
      rem = crc_after_octet(rem, frame_octets[i]);
    end
    frame_octets[n - 3] = rem[23:16];
    frame_octets[n - 2] = rem[15:8];
    frame_octets[n - 1] = rem[7:0];
  endtask

  function automatic logic [4:0] type_in_class(input int k);
    case (k)
      0:       return 5'($urandom_range(1, 4));
      1:       return 5'($urandom_range(5, 8));
      2:       return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(20, 22))
                                                  : 5'($urandom_range(9, 18));
      3:       return 5'd19;
      default: return ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(23, 31));
    endcase
  endfunction

  // sender pause until every report is back
  task automatic wait_for_reports();
    frame_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // extremes: one-byte frames, a short frame with good parity, a clean long velocity frame
  task automatic test_corner_frames();
    src_gap_max  = 0;
    sink_gap_max = 0;
    frame_octets = '{8'h00};
    send_frame();
    frame_octets = '{8'hFF};
    send_frame();
    build_frame(7, 5'd0);
    frame_octets[0] = 8'h5D;
    seal_frame();
    send_frame();
    build_frame(14, 5'd19);
    frame_octets[0] = 8'hFF;
    for (int i = 1; i <= 3; i++) begin
      frame_octets[i] = 8'hFF;
    end
    for (int i = 5; i <= 10; i++) begin
      frame_octets[i] = 8'h00;
    end
    frame_octets[4][2:0] = 3'b000;
    seal_frame();
    send_frame();
    wait_for_reports();
  endtask

  // frames of legal length with good parity, type codes cycling through every message class
  task automatic test_well_formed_frames();
    for (int f = 0; f < 22; f++) begin
      src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 14;
      sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      build_frame(($urandom_range(0, 9) < 7) ? 14 : 7, type_in_class(f % 5));
      seal_frame();
      send_frame();
    end
    wait_for_reports();
  endtask

  // bit errors, wrong lengths and overlong frames
  task automatic test_damaged_frames();
    int n;
    for (int f = 0; f < 10; f++) begin
      src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 14;
      sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      case ($urandom_range(0, 2))
        0, 1: begin
          n = ($urandom_range(0, 1) == 0) ? 14 : 7;
          build_frame(n, type_in_class($urandom_range(0, 3)));
          seal_frame();
          frame_octets[$urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(15, 18);
          end else begin
            n = $urandom_range(1, 12);
            if (n == 7) begin
              n = 13;
            end
          end
          build_frame(n, type_in_class($urandom_range(0, 3)));
          seal_frame();
        end
      endcase
      send_frame();
    end
    wait_for_reports();
  endtask

  // receiver holds off long enough for the report buffer to fill and stall input
  task automatic test_report_backpressure();
    src_gap_max      = 0;
    sink_gap_max     = 0;
    sink_hold_cycles = LONG_HOLD;
    for (int f = 0; f < 6; f++) begin
      build_frame(7, 5'd0);
      seal_frame();
      send_frame();
    end
    wait_for_reports();
  endtask

  initial begin
    rst                 <= 1'b1;
    frame_ch.valid      <= 1'b0;
    frame_ch.frame_byte <= 8'h00;
    frame_ch.last_byte  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_corner_frames();
    test_well_formed_frames();
    test_damaged_frames();
    test_report_backpressure();

    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      mismatch_count += expected_reports.size();
      $display("%0d reports never arrived", expected_reports.size());
    end

    $display("sent %0d bytes in %0d frames, checked %0d reports", octets_sent,
             frames_sent, reports_checked);
    $display("statuses seen: ok %0d, bad type %0d, bad length %0d, bad parity %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
